// ===== rtl/usq_pkg.sv =====
package usq_pkg;

    // Field widths of the request and response beats.
    localparam int CMD_W   = 2;
    localparam int EVENT_W = 4;
    localparam int STATE_W = 3;
    localparam int ERROR_W = 3;
    localparam int RETRY_W = 8;
    localparam int COUNT_W = 32;

    // Configuration port geometry.
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // Register index, taken from the word address bit.
    localparam logic REG_RETRY_LIMIT = 1'b0;
    localparam logic [RETRY_W-1:0] RETRY_LIMIT_RESET = 8'd3;

    // Commands.
    localparam logic [CMD_W-1:0] CMD_ENQUEUE    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PROCESS    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FLUSH      = 2'd2;
    localparam logic [CMD_W-1:0] CMD_SOFT_RESET = 2'd3;

    // Event codes.
    localparam logic [EVENT_W-1:0] EVT_CHECK      = 4'd0;
    localparam logic [EVENT_W-1:0] EVT_FOUND      = 4'd1;
    localparam logic [EVENT_W-1:0] EVT_NOT_FOUND  = 4'd2;
    localparam logic [EVENT_W-1:0] EVT_DOWNLOADED = 4'd3;
    localparam logic [EVENT_W-1:0] EVT_VERIFIED   = 4'd4;
    localparam logic [EVENT_W-1:0] EVT_APPLIED    = 4'd5;
    localparam logic [EVENT_W-1:0] EVT_REBOOTED   = 4'd6;
    localparam logic [EVENT_W-1:0] EVT_FAILED     = 4'd7;
    localparam logic [EVENT_W-1:0] EVT_TIMEOUT    = 4'd8;
    localparam logic [EVENT_W-1:0] EVT_ROLLBACK   = 4'd9;
    localparam logic [EVENT_W-1:0] EVT_RETRY      = 4'd10;
    localparam logic [EVENT_W-1:0] EVT_RESET      = 4'd11;

    // Error codes.
    localparam logic [ERROR_W-1:0] ERR_OK        = 3'd0;
    localparam logic [ERROR_W-1:0] ERR_TIMEOUT   = 3'd1;
    localparam logic [ERROR_W-1:0] ERR_HASH      = 3'd2;
    localparam logic [ERROR_W-1:0] ERR_FLASH     = 3'd3;
    localparam logic [ERROR_W-1:0] ERR_ROLLBACK  = 3'd4;
    localparam logic [ERROR_W-1:0] ERR_BAD_STATE = 3'd5;

    // Sequencer phases, one-hot. Bit position equals the external state code.
    localparam int PHASE_COUNT = 8;

    typedef enum logic [PHASE_COUNT-1:0] {
        PH_APP      = 8'b0000_0001,
        PH_CHECK    = 8'b0000_0010,
        PH_DOWNLOAD = 8'b0000_0100,
        PH_VERIFY   = 8'b0000_1000,
        PH_APPLY    = 8'b0001_0000,
        PH_REBOOT   = 8'b0010_0000,
        PH_ROLLBACK = 8'b0100_0000,
        PH_ERROR    = 8'b1000_0000
    } phase_t;

    // One response beat.
    typedef struct packed {
        logic               queue_full;
        logic               event_taken;
        logic               transitioned;
        logic [STATE_W-1:0] previous_state;
        logic [STATE_W-1:0] current_state;
        logic               error_entered;
        logic [ERROR_W-1:0] error_code;
        logic [RETRY_W-1:0] retries;
        logic [COUNT_W-1:0] events_handled;
    } result_t;

    // Binary state code of a one-hot phase.
    function automatic logic [STATE_W-1:0] phase_code(phase_t p);
        logic [STATE_W-1:0] c;
        c = '0;
        for (int i = 0; i < PHASE_COUNT; i++)
        begin
            if (p[i])
            begin
                c = c | STATE_W'(i);
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/usq_req_if.sv =====
interface usq_req_if;

    logic                         valid;
    logic                         ready;
    logic [usq_pkg::CMD_W-1:0]    command;
    logic [usq_pkg::EVENT_W-1:0]  event_code;

    modport source (output valid, output command, output event_code, input ready);
    modport sink   (input valid, input command, input event_code, output ready);

endinterface

// ===== rtl/usq_rsp_if.sv =====
interface usq_rsp_if;

    logic                         valid;
    logic                         ready;
    logic                         queue_full;
    logic                         event_taken;
    logic                         transitioned;
    logic [usq_pkg::STATE_W-1:0]  previous_state;
    logic [usq_pkg::STATE_W-1:0]  current_state;
    logic                         error_entered;
    logic [usq_pkg::ERROR_W-1:0]  error_code;
    logic [usq_pkg::RETRY_W-1:0]  retries;
    logic [usq_pkg::COUNT_W-1:0]  events_handled;

    modport source (
        output valid, output queue_full, output event_taken, output transitioned,
        output previous_state, output current_state, output error_entered,
        output error_code, output retries, output events_handled,
        input ready
    );
    modport sink (
        input valid, input queue_full, input event_taken, input transitioned,
        input previous_state, input current_state, input error_entered,
        input error_code, input retries, input events_handled,
        output ready
    );

endinterface

// ===== rtl/usq_ram.sv =====
module usq_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port; a read of the address
    // being written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/update_sequencer_with_event_queue_top.sv =====
// A request beat is decided in the cycle it is accepted; its response is registered in the
// output register, or in the skid register while the output register holds a beat. One
// request beat per cycle is taken while the skid register is empty; the queue RAM head is
// prefetched every cycle. A two-entry output buffer takes one more request beat while a
// response beat waits. Reset (rst_n, asynchronous, active low) clears the pointers, phase,
// error code, counters and output buffer and sets retry_limit to 3; queue storage is not cleared.
module update_sequencer_with_event_queue_top #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    usq_req_if.sink                          req,
    usq_rsp_if.source                        rsp,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [usq_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [usq_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [usq_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    logic [usq_pkg::RETRY_W-1:0] retry_limit_reg;

    logic [PTR_W-1:0]            rp_reg, rp_next, rp_inc;
    logic [PTR_W-1:0]            wp_reg, wp_next, wp_inc;
    usq_pkg::phase_t             phase_reg, phase_next, target;
    logic [usq_pkg::ERROR_W-1:0] err_reg, err_next;
    logic [usq_pkg::RETRY_W-1:0] retry_reg, retry_next, retry_inc;
    logic [usq_pkg::COUNT_W-1:0] count_reg, count_next;
    logic [usq_pkg::ERROR_W-1:0] err_upd;
    logic [usq_pkg::RETRY_W-1:0] retry_upd;

    logic                        wr_en;
    logic [usq_pkg::EVENT_W-1:0] ram_rd_data;
    logic [usq_pkg::EVENT_W-1:0] head_ev;
    logic                        byp_valid_reg;
    logic [usq_pkg::EVENT_W-1:0] byp_data_reg;

    logic                        accept;
    usq_pkg::result_t            res;
    usq_pkg::result_t            out_data_reg, skid_data_reg;
    logic                        out_valid_reg, skid_valid_reg;
    logic                        out_fire;

    // Configuration port: one register, decoded from the word address bit.
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            retry_limit_reg <= usq_pkg::RETRY_LIMIT_RESET;
        end
        else if (psel && penable && pwrite && pready
                 && paddr[2] == usq_pkg::REG_RETRY_LIMIT)
        begin
            retry_limit_reg <= pwdata[usq_pkg::RETRY_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == usq_pkg::REG_RETRY_LIMIT)
        begin
            prdata = usq_pkg::APB_DATA_W'(retry_limit_reg);
        end
    end

    // Handshake: the output buffer takes a second beat before it stalls the request side.
    assign accept    = req.valid && req.ready;
    assign req.ready = !skid_valid_reg;
    assign out_fire  = out_valid_reg && rsp.ready;

    // Ring pointer increments with wrap at the queue depth.
    assign rp_inc = (rp_reg == LAST_PTR) ? '0 : rp_reg + 1'b1;
    assign wp_inc = (wp_reg == LAST_PTR) ? '0 : wp_reg + 1'b1;

    // Queue head: RAM data read at the pointer of the previous edge, or the beat
    // written to that same slot at that edge.
    assign head_ev = byp_valid_reg ? byp_data_reg : ram_rd_data;

    assign retry_inc = retry_reg + 1'b1;

    // Event decision: global events first, then the rules of the current phase.
    always_comb
    begin
        target   = phase_reg;
        err_next = err_reg;
        retry_next = retry_reg;
        if (head_ev == usq_pkg::EVT_RESET)
        begin
            target = usq_pkg::PH_APP;
        end
        else if (head_ev == usq_pkg::EVT_TIMEOUT)
        begin
            err_next = usq_pkg::ERR_TIMEOUT;
            target   = usq_pkg::PH_ERROR;
        end
        else if (head_ev == usq_pkg::EVT_RETRY)
        begin
            retry_next = retry_inc;
            if (retry_inc >= retry_limit_reg)
            begin
                err_next = usq_pkg::ERR_BAD_STATE;
                target   = usq_pkg::PH_ERROR;
            end
        end
        else
        begin
            unique case (phase_reg)
                usq_pkg::PH_APP:
                begin
                    if (head_ev == usq_pkg::EVT_CHECK) target = usq_pkg::PH_CHECK;
                end
                usq_pkg::PH_CHECK:
                begin
                    if (head_ev == usq_pkg::EVT_FOUND) target = usq_pkg::PH_DOWNLOAD;
                    if (head_ev == usq_pkg::EVT_NOT_FOUND) target = usq_pkg::PH_APP;
                    if (head_ev == usq_pkg::EVT_FAILED)
                    begin
                        err_next = usq_pkg::ERR_BAD_STATE;
                        target   = usq_pkg::PH_ERROR;
                    end
                end
                usq_pkg::PH_DOWNLOAD:
                begin
                    if (head_ev == usq_pkg::EVT_DOWNLOADED) target = usq_pkg::PH_VERIFY;
                    if (head_ev == usq_pkg::EVT_FAILED)
                    begin
                        err_next = usq_pkg::ERR_BAD_STATE;
                        target   = usq_pkg::PH_ERROR;
                    end
                end
                usq_pkg::PH_VERIFY:
                begin
                    if (head_ev == usq_pkg::EVT_VERIFIED) target = usq_pkg::PH_APPLY;
                    if (head_ev == usq_pkg::EVT_FAILED)
                    begin
                        err_next = usq_pkg::ERR_HASH;
                        target   = usq_pkg::PH_ERROR;
                    end
                end
                usq_pkg::PH_APPLY:
                begin
                    if (head_ev == usq_pkg::EVT_APPLIED) target = usq_pkg::PH_REBOOT;
                    if (head_ev == usq_pkg::EVT_FAILED)
                    begin
                        err_next = usq_pkg::ERR_FLASH;
                        target   = usq_pkg::PH_ERROR;
                    end
                end
                usq_pkg::PH_REBOOT:
                begin
                    if (head_ev == usq_pkg::EVT_REBOOTED) target = usq_pkg::PH_APP;
                end
                usq_pkg::PH_ROLLBACK:
                begin
                    if (head_ev == usq_pkg::EVT_APPLIED) target = usq_pkg::PH_REBOOT;
                    if (head_ev == usq_pkg::EVT_FAILED)
                    begin
                        err_next = usq_pkg::ERR_ROLLBACK;
                        target   = usq_pkg::PH_ERROR;
                    end
                end
                usq_pkg::PH_ERROR:
                begin
                    if (head_ev == usq_pkg::EVT_ROLLBACK) target = usq_pkg::PH_ROLLBACK;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Command handling and the response beat for the accepted request.
    always_comb
    begin
        rp_next    = rp_reg;
        wp_next    = wp_reg;
        phase_next = phase_reg;
        count_next = count_reg;
        wr_en      = 1'b0;
        res        = '0;
        res.previous_state = usq_pkg::phase_code(phase_reg);

        if (accept)
        begin
            unique case (req.command)
                usq_pkg::CMD_ENQUEUE:
                begin
                    if (wp_inc == rp_reg)
                    begin
                        res.queue_full = 1'b1;
                    end
                    else
                    begin
                        wr_en   = 1'b1;
                        wp_next = wp_inc;
                    end
                end
                usq_pkg::CMD_PROCESS:
                begin
                    if (rp_reg != wp_reg)
                    begin
                        rp_next         = rp_inc;
                        count_next      = count_reg + 1'b1;
                        res.event_taken = 1'b1;
                        if (target != phase_reg)
                        begin
                            phase_next       = target;
                            res.transitioned = 1'b1;
                            res.error_entered = (target == usq_pkg::PH_ERROR);
                        end
                    end
                end
                usq_pkg::CMD_FLUSH:
                begin
                    rp_next = '0;
                    wp_next = '0;
                end
                default:
                begin
                    phase_next       = usq_pkg::PH_APP;
                    res.transitioned = 1'b1;
                end
            endcase
        end

        res.current_state  = usq_pkg::phase_code(phase_next);
        res.error_code     = err_upd;
        res.retries        = retry_upd;
        res.events_handled = count_next;
    end

    // Error code and retry count follow the same command decode.
    always_comb
    begin
        err_upd   = err_reg;
        retry_upd = retry_reg;
        if (accept && req.command == usq_pkg::CMD_PROCESS && rp_reg != wp_reg)
        begin
            err_upd   = err_next;
            retry_upd = (target != phase_reg) ? '0 : retry_next;
        end
        else if (accept && req.command == usq_pkg::CMD_SOFT_RESET)
        begin
            err_upd   = usq_pkg::ERR_OK;
            retry_upd = '0;
        end
    end

    // Sequencer state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rp_reg        <= '0;
            wp_reg        <= '0;
            phase_reg     <= usq_pkg::PH_APP;
            err_reg       <= usq_pkg::ERR_OK;
            retry_reg     <= '0;
            count_reg     <= '0;
            byp_valid_reg <= 1'b0;
        end
        else
        begin
            rp_reg        <= rp_next;
            wp_reg        <= wp_next;
            phase_reg     <= phase_next;
            err_reg       <= err_upd;
            retry_reg     <= retry_upd;
            count_reg     <= count_next;
            byp_valid_reg <= wr_en && (wp_reg == rp_next);
        end
    end

    always_ff @(posedge clk)
    begin
        byp_data_reg <= req.event_code;
    end

    // Event storage; the read address is the head pointer of the next cycle.
    usq_ram #(
        .WIDTH (usq_pkg::EVENT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_event_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wp_reg),
        .wr_data (req.event_code),
        .rd_addr (rp_next),
        .rd_data (ram_rd_data)
    );

    // Two-entry output buffer: output register plus skid register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_fire)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= accept;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_fire && skid_valid_reg)
        begin
            out_data_reg <= skid_data_reg;
        end
        else if (accept && (out_fire || !out_valid_reg))
        begin
            out_data_reg <= res;
        end
        if (accept && out_valid_reg && !out_fire)
        begin
            skid_data_reg <= res;
        end
    end

    // Response fields.
    assign rsp.valid          = out_valid_reg;
    assign rsp.queue_full     = out_data_reg.queue_full;
    assign rsp.event_taken    = out_data_reg.event_taken;
    assign rsp.transitioned   = out_data_reg.transitioned;
    assign rsp.previous_state = out_data_reg.previous_state;
    assign rsp.current_state  = out_data_reg.current_state;
    assign rsp.error_entered  = out_data_reg.error_entered;
    assign rsp.error_code     = out_data_reg.error_code;
    assign rsp.retries        = out_data_reg.retries;
    assign rsp.events_handled = out_data_reg.events_handled;

    // Checks.
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a beat while the output register is empty");

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (rp_reg <= LAST_PTR) && (wp_reg <= LAST_PTR))
        else $error("queue pointer beyond the queue depth");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && res.event_taken) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("event counter did not advance on a taken event");

    a_error_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && res.error_entered) |=> (phase_reg == usq_pkg::PH_ERROR))
        else $error("error entry reported without reaching the error phase");

    a_bypass_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        byp_valid_reg |-> $past(wr_en))
        else $error("head bypass set without a queue write");

endmodule
